FILE: rtl/hkrb_pkg.sv
`default_nettype none

package hkrb_pkg;

   localparam int KEY_SLOTS   = 6;
   localparam int SHOWN_SLOTS = 6;

   localparam logic [7:0] MOD_SHIFT = 8'h02;

   typedef enum logic [1:0] {
      REQ_PRESS   = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_CHAR    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_ROLLOVER    = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } status_type;

   typedef logic [KEY_SLOTS-1:0][7:0]   slot_vec_type;
   typedef logic [SHOWN_SLOTS-1:0][7:0] shown_vec_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] modifier_bits;
      logic [7:0] usage_code;
      logic [6:0] ascii_char;
      logic       send_report;
   } req_word_type;

   typedef struct packed {
      logic [7:0]    report_modifiers;
      shown_vec_type slots;
      logic [1:0]    status;
      logic          last;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic load_first;
      logic load_second;
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit_first;
      logic two_words;
      logic out_free;
   } dp_stat_type;

   typedef struct packed {
      logic [7:0] mods;
      logic [7:0] usage;
   } char_map_type;

   // ascii to modifier and usage, usage zero when there is no mapping
   function automatic char_map_type char_map(input logic [6:0] c);
      char_map_type res;
      logic [7:0]   cw;
      res = '0;
      cw  = {1'b0, c};
      case (c) inside
         [7'h61:7'h7a]: res.usage = cw - 8'h61 + 8'h04;
         [7'h41:7'h5a]: begin
            res.mods  = MOD_SHIFT;
            res.usage = cw - 8'h41 + 8'h04;
         end
         [7'h31:7'h39]: res.usage = cw - 8'h31 + 8'h1e;
         7'h30: res.usage = 8'h27;
         7'h0a: res.usage = 8'h28;
         7'h09: res.usage = 8'h2b;
         7'h20: res.usage = 8'h2c;
         7'h2d: res.usage = 8'h2d;
         7'h3d: res.usage = 8'h2e;
         7'h5b: res.usage = 8'h2f;
         7'h5d: res.usage = 8'h30;
         7'h5c: res.usage = 8'h31;
         7'h3b: res.usage = 8'h33;
         7'h27: res.usage = 8'h34;
         7'h60: res.usage = 8'h35;
         7'h2c: res.usage = 8'h36;
         7'h2e: res.usage = 8'h37;
         7'h2f: res.usage = 8'h38;
         7'h5f: res = '{MOD_SHIFT, 8'h2d};
         7'h2b: res = '{MOD_SHIFT, 8'h2e};
         7'h7b: res = '{MOD_SHIFT, 8'h2f};
         7'h7d: res = '{MOD_SHIFT, 8'h30};
         7'h7c: res = '{MOD_SHIFT, 8'h31};
         7'h3a: res = '{MOD_SHIFT, 8'h33};
         7'h22: res = '{MOD_SHIFT, 8'h34};
         7'h7e: res = '{MOD_SHIFT, 8'h35};
         7'h3c: res = '{MOD_SHIFT, 8'h36};
         7'h3e: res = '{MOD_SHIFT, 8'h37};
         7'h3f: res = '{MOD_SHIFT, 8'h38};
         7'h21: res = '{MOD_SHIFT, 8'h1e};
         7'h40: res = '{MOD_SHIFT, 8'h1f};
         7'h23: res = '{MOD_SHIFT, 8'h20};
         7'h24: res = '{MOD_SHIFT, 8'h21};
         7'h25: res = '{MOD_SHIFT, 8'h22};
         7'h5e: res = '{MOD_SHIFT, 8'h23};
         7'h26: res = '{MOD_SHIFT, 8'h24};
         7'h2a: res = '{MOD_SHIFT, 8'h25};
         7'h28: res = '{MOD_SHIFT, 8'h26};
         7'h29: res = '{MOD_SHIFT, 8'h27};
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/hkrb_if.sv
`default_nettype none

interface hkrb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] modifier_bits;
   logic [7:0] usage_code;
   logic [6:0] ascii_char;
   logic       send_report;

   modport source (output valid, req_type, modifier_bits, usage_code, ascii_char,
                   send_report, input ready);
   modport sink (input valid, req_type, modifier_bits, usage_code, ascii_char,
                 send_report, output ready);
endinterface

interface hkrb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_modifiers;
   logic [7:0] slot_a;
   logic [7:0] slot_b;
   logic [7:0] slot_c;
   logic [7:0] slot_d;
   logic [7:0] slot_e;
   logic [7:0] slot_f;
   logic [1:0] status;
   logic       last;

   modport source (output valid, report_modifiers, slot_a, slot_b, slot_c, slot_d, slot_e,
                   slot_f, status, last, input ready);
   modport sink (input valid, report_modifiers, slot_a, slot_b, slot_c, slot_d, slot_e,
                 slot_f, status, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/hkrb_ctrl.sv
`default_nettype none

module hkrb_ctrl import hkrb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire dp_stat_type  stat,
   output ctrl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_SECOND = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stat.emit_first || stat.out_free) begin
               cmd.commit     = 1'b1;
               cmd.load_first = stat.emit_first;
               state_in       = stat.two_words ? ST_SECOND : ST_IDLE;
            end
         end
         ST_SECOND: begin
            if (stat.out_free) begin
               cmd.load_second = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/hkrb_dp.sv
`default_nettype none

module hkrb_dp import hkrb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_word_type req_word,
   input  wire logic         rsp_ready,
   input  wire ctrl_cmd_type cmd,
   output dp_stat_type       stat,
   output rsp_word_type      rsp_word,
   output logic              rsp_valid
);

   req_word_type item_ff;
   logic [7:0]   held_mods_ff;
   slot_vec_type slots_ff;
   rsp_word_type out_ff;
   logic         out_valid_ff;

   char_map_type             cmap;
   logic                     is_char;
   logic                     is_press;
   logic [7:0]               press_mod;
   logic [7:0]               press_use;
   logic [KEY_SLOTS-1:0]     hit;
   logic [KEY_SLOTS-1:0]     free;
   logic [KEY_SLOTS-1:0]     after;
   logic [KEY_SLOTS:0][7:0]  ext;
   logic                     prev_nz;
   logic                     run;
   logic                     held_key;
   logic                     insert;
   logic                     rollover;
   logic                     unsupported;
   logic                     err;
   logic [1:0]               err_status;
   logic [7:0]               nxt_mods;
   slot_vec_type             nxt_slots;
   rsp_word_type             first_word;
   rsp_word_type             second_word;

   function automatic shown_vec_type to_shown(input slot_vec_type s);
      shown_vec_type r;
      r = '0;
      for (int j = 0; j < SHOWN_SLOTS; j++) begin
         if (j < KEY_SLOTS) begin
            r[j] = s[j];
         end
      end
      return r;
   endfunction

   always_comb begin
      cmap        = char_map(item_ff.ascii_char);
      is_char     = (item_ff.req_type == REQ_CHAR);
      is_press    = (item_ff.req_type == REQ_PRESS) || is_char;
      press_mod   = is_char ? cmap.mods : item_ff.modifier_bits;
      press_use   = is_char ? cmap.usage : item_ff.usage_code;
      unsupported = is_char && (cmap.usage == 8'h00);

      // slots stay packed, so the first free slot follows the last used one
      prev_nz = 1'b1;
      run     = 1'b0;
      ext     = {8'h00, slots_ff};
      for (int i = 0; i < KEY_SLOTS; i++) begin
         hit[i]   = (slots_ff[i] == press_use);
         free[i]  = (slots_ff[i] == 8'h00) && prev_nz;
         prev_nz  = (slots_ff[i] != 8'h00);
         run      = run || ((slots_ff[i] == item_ff.usage_code) &&
                            (item_ff.usage_code != 8'h00));
         after[i] = run;
      end

      held_key = |hit;
      insert   = (press_use != 8'h00) && !held_key;
      rollover = is_press && insert && (slots_ff[KEY_SLOTS-1] != 8'h00);
      err      = rollover || unsupported;

      if (unsupported) begin
         err_status = STATUS_UNSUPPORTED;
      end else if (rollover) begin
         err_status = STATUS_ROLLOVER;
      end else begin
         err_status = STATUS_OK;
      end

      nxt_mods  = held_mods_ff;
      nxt_slots = slots_ff;
      case (item_ff.req_type)
         REQ_PRESS, REQ_CHAR: begin
            nxt_mods = held_mods_ff | press_mod;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               if (insert && free[i]) begin
                  nxt_slots[i] = press_use;
               end
            end
         end
         REQ_RELEASE: begin
            nxt_mods = held_mods_ff & ~item_ff.modifier_bits;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               nxt_slots[i] = after[i] ? ext[i+1] : ext[i];
            end
         end
         REQ_CLEAR: begin
            nxt_mods  = '0;
            nxt_slots = '0;
         end
         default: begin
            nxt_mods = held_mods_ff;
         end
      endcase

      first_word.report_modifiers = err ? held_mods_ff : nxt_mods;
      first_word.slots            = to_shown(err ? slots_ff : nxt_slots);
      first_word.status           = err_status;
      first_word.last             = err || !is_char;

      second_word.report_modifiers = held_mods_ff;
      second_word.slots            = to_shown(slots_ff);
      second_word.status           = STATUS_OK;
      second_word.last             = 1'b1;

      stat.emit_first = err || is_char || item_ff.send_report;
      stat.two_words  = is_char && !err;
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
      end
      if (cmd.load_first) begin
         out_ff <= first_word;
      end else if (cmd.load_second) begin
         out_ff <= second_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_mods_ff <= '0;
         slots_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit && !is_char && !err) begin
            held_mods_ff <= nxt_mods;
            slots_ff     <= nxt_slots;
         end
         if (cmd.load_first || cmd.load_second) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_word  = out_ff;
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/hid_keyboard_report_builder.sv
// Boot-keyboard report builder: holds one modifier byte and six packed key slots.
// req_chan carries one event word: press, release, release all or type character.
// rsp_chan carries report words: modifiers, six slots, status and a last flag.
// Both channels move a word when valid and ready are high at a rising edge.
// An event is captured, then executed against the held report in a separate step;
// a typed character then adds a further step that loads its second report.
// The execute step is a single pass of the slot compare and insert/compact
// logic; the next event is taken once the controller is back in idle.
// Press, release and release all emit a report only when send_report is set;
// a rollover or an unmapped character always emits one error report.
// A single output register holds the pending report; the next event is taken
// while it waits, and execution stalls only if it must emit into a full register.
// Synchronous reset clears the held report, the controller and the output valid.
`default_nettype none

module hid_keyboard_report_builder import hkrb_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   hkrb_req_if.sink   req_chan,
   hkrb_rsp_if.source rsp_chan
);

   req_word_type req_word;
   rsp_word_type rsp_word;
   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         ready;
   logic         rsp_valid;

   assign req_word.req_type      = req_chan.req_type;
   assign req_word.modifier_bits = req_chan.modifier_bits;
   assign req_word.usage_code    = req_chan.usage_code;
   assign req_word.ascii_char    = req_chan.ascii_char;
   assign req_word.send_report   = req_chan.send_report;
   assign req_chan.ready         = ready;

   hkrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hkrb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid)
   );

   assign rsp_chan.valid            = rsp_valid;
   assign rsp_chan.report_modifiers = rsp_word.report_modifiers;
   assign rsp_chan.slot_a           = rsp_word.slots[0];
   assign rsp_chan.slot_b           = rsp_word.slots[1];
   assign rsp_chan.slot_c           = rsp_word.slots[2];
   assign rsp_chan.slot_d           = rsp_word.slots[3];
   assign rsp_chan.slot_e           = rsp_word.slots[4];
   assign rsp_chan.slot_f           = rsp_word.slots[5];
   assign rsp_chan.status           = rsp_word.status;
   assign rsp_chan.last             = rsp_word.last;

   // an error report always closes its event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != STATUS_OK) |-> rsp_word.last)
      else $error("error report without last");

   // the two loads never collide and only happen with room in the output register
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_first || cmd.load_second) |-> stat.out_free &&
         !(cmd.load_first && cmd.load_second))
      else $error("report loaded into a busy output register");

   // an accepted event is executed before the next one is taken
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && ready |=> !ready)
      else $error("event accepted back to back");

   // after a non-final report load the controller stays busy for its closing report
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_first && stat.two_words |=> !ready)
      else $error("second report skipped");

endmodule

`default_nettype wire
